@@ src/vrc_pkg.sv @@
package vrc_pkg;

  localparam int EXP_TABLE_ENTRIES = 256;
  localparam int IDX_W = $clog2(EXP_TABLE_ENTRIES);
  localparam int PROD_W = 32 + IDX_W + 1;
  localparam int EXP_SHIFT = 20;
  localparam logic [16:0] ONE_Q16 = 17'h10000;

  typedef struct packed {
    logic [15:0] depth;
    logic [15:0] density;
    logic [15:0] red_in;
    logic [15:0] green_in;
    logic [15:0] blue_in;
    logic        last_sample;
  } vrc_in_t;

  typedef struct packed {
    logic [15:0] weight;
    logic [15:0] red_out;
    logic [15:0] green_out;
    logic [15:0] blue_out;
    logic        ray_end;
  } vrc_out_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic lookup;
    logic alpha_last;
    logic wt;
    logic col;
    logic emit;
    logic use_cur;
    logic retire;
  } vrc_cmd_t;

  typedef struct packed {
    logic holding;
    logic in_last;
    logic cur_last;
    logic out_room;
  } vrc_sts_t;

  typedef logic [16:0] exp_table_t [EXP_TABLE_ENTRIES];

  function automatic logic [16:0] exp_entry(int unsigned i);
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] term;
    logic [63:0] s;
    y = (64'(i) << 35) / EXP_TABLE_ENTRIES;
    t = y >> 8;
    term = 64'd1 << 31;
    s = term;
    term = (term * t) >> 31;
    s = (s >= term) ? s - term : 64'd0;
    term = ((term * t) >> 31) / 2;
    s = s + term;
    term = ((term * t) >> 31) / 3;
    s = (s >= term) ? s - term : 64'd0;
    term = ((term * t) >> 31) / 4;
    s = s + term;
    term = ((term * t) >> 31) / 5;
    s = (s >= term) ? s - term : 64'd0;
    if (s > (64'd1 << 31)) begin
      s = 64'd1 << 31;
    end
    for (int k = 0; k < 8; k++) begin
      s = (s * s) >> 31;
    end
    return 17'((s + (64'd1 << 14)) >> 15);
  endfunction

  function automatic exp_table_t build_exp_table();
    exp_table_t tbl;
    for (int i = 0; i < EXP_TABLE_ENTRIES; i++) begin
      tbl[i] = exp_entry(i);
    end
    return tbl;
  endfunction

  localparam exp_table_t EXP_TABLE = build_exp_table();

endpackage

@@ src/vrc_ctrl.sv @@
module vrc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrc_pkg::vrc_sts_t sts,
  output vrc_pkg::vrc_cmd_t cmd
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_RETIRE  = 4'd1;
  localparam logic [3:0] S_F_MUL   = 4'd2;
  localparam logic [3:0] S_F_EXP   = 4'd3;
  localparam logic [3:0] S_F_WT    = 4'd4;
  localparam logic [3:0] S_F_COL   = 4'd5;
  localparam logic [3:0] S_F_EMIT  = 4'd6;
  localparam logic [3:0] S_L_ALPHA = 4'd7;
  localparam logic [3:0] S_L_WT    = 4'd8;
  localparam logic [3:0] S_L_COL   = 4'd9;
  localparam logic [3:0] S_L_EMIT  = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          if (sts.holding) begin
            state_nxt = S_F_MUL;
          end else if (sts.in_last) begin
            state_nxt = S_L_ALPHA;
          end else begin
            state_nxt = S_RETIRE;
          end
        end
      end
      S_RETIRE: begin
        cmd.retire = 1'b1;
        state_nxt = S_IDLE;
      end
      S_F_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = S_F_EXP;
      end
      S_F_EXP: begin
        cmd.lookup = 1'b1;
        state_nxt = S_F_WT;
      end
      S_F_WT: begin
        cmd.wt = 1'b1;
        state_nxt = S_F_COL;
      end
      S_F_COL: begin
        cmd.col = 1'b1;
        state_nxt = S_F_EMIT;
      end
      S_F_EMIT: begin
        if (sts.out_room) begin
          cmd.emit = 1'b1;
          if (sts.cur_last) begin
            state_nxt = S_L_ALPHA;
          end else begin
            cmd.retire = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_L_ALPHA: begin
        cmd.alpha_last = 1'b1;
        state_nxt = S_L_WT;
      end
      S_L_WT: begin
        cmd.wt = 1'b1;
        state_nxt = S_L_COL;
      end
      S_L_COL: begin
        cmd.col = 1'b1;
        cmd.use_cur = 1'b1;
        state_nxt = S_L_EMIT;
      end
      S_L_EMIT: begin
        cmd.use_cur = 1'b1;
        if (sts.out_room) begin
          cmd.emit = 1'b1;
          cmd.retire = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ src/vrc_dp.sv @@
module vrc_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  vrc_pkg::vrc_in_t   in_data,
  input  vrc_pkg::vrc_cmd_t  cmd,
  output vrc_pkg::vrc_sts_t  sts,
  output logic               out_valid,
  input  logic               out_stall,
  output vrc_pkg::vrc_out_t  out_data
);

  vrc_pkg::vrc_in_t cur_r;
  logic [15:0] held_depth_r;
  logic [15:0] held_density_r;
  logic [15:0] held_red_r;
  logic [15:0] held_green_r;
  logic [15:0] held_blue_r;
  logic        holding_r;
  logic [16:0] trans_r;
  logic [15:0] sum_red_r;
  logic [15:0] sum_green_r;
  logic [15:0] sum_blue_r;
  logic [31:0] x_r;
  logic [16:0] alpha_r;
  logic [16:0] w_r;
  logic        out_valid_r;
  vrc_pkg::vrc_out_t out_data_r;

  logic [15:0] delta;
  logic [vrc_pkg::PROD_W-1:0] idx_prod;
  logic [vrc_pkg::PROD_W-1:0] idx_full;
  logic [16:0] exp_val;
  logic [16:0] exp_sat;
  logic [33:0] w_prod;
  logic [33:0] t_prod;
  logic [15:0] col_r_sel;
  logic [15:0] col_g_sel;
  logic [15:0] col_b_sel;
  logic [32:0] r_prod;
  logic [32:0] g_prod;
  logic [32:0] b_prod;
  logic [16:0] r_sum;
  logic [16:0] g_sum;
  logic [16:0] b_sum;

  assign delta = (cur_r.depth >= held_depth_r) ? cur_r.depth - held_depth_r : 16'd0;

  assign idx_prod = vrc_pkg::PROD_W'(x_r) * vrc_pkg::PROD_W'(vrc_pkg::EXP_TABLE_ENTRIES);
  assign idx_full = idx_prod >> vrc_pkg::EXP_SHIFT;
  assign exp_val = (idx_full < vrc_pkg::PROD_W'(vrc_pkg::EXP_TABLE_ENTRIES)) ?
                   vrc_pkg::EXP_TABLE[idx_full[vrc_pkg::IDX_W-1:0]] : 17'd0;
  assign exp_sat = (exp_val > vrc_pkg::ONE_Q16) ? vrc_pkg::ONE_Q16 : exp_val;

  assign w_prod = 34'(alpha_r) * 34'(trans_r);
  assign t_prod = 34'(trans_r) * 34'(vrc_pkg::ONE_Q16 - alpha_r);

  assign col_r_sel = cmd.use_cur ? cur_r.red_in : held_red_r;
  assign col_g_sel = cmd.use_cur ? cur_r.green_in : held_green_r;
  assign col_b_sel = cmd.use_cur ? cur_r.blue_in : held_blue_r;
  assign r_prod = 33'(w_r) * 33'(col_r_sel);
  assign g_prod = 33'(w_r) * 33'(col_g_sel);
  assign b_prod = 33'(w_r) * 33'(col_b_sel);
  assign r_sum = {1'b0, sum_red_r} + r_prod[32:16];
  assign g_sum = {1'b0, sum_green_r} + g_prod[32:16];
  assign b_sum = {1'b0, sum_blue_r} + b_prod[32:16];

  assign sts.holding = holding_r;
  assign sts.in_last = in_data.last_sample;
  assign sts.cur_last = cur_r.last_sample;
  assign sts.out_room = !out_valid_r || !out_stall;

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cur_r <= in_data;
    end
    if (cmd.mul) begin
      x_r <= 32'(held_density_r) * 32'(delta);
    end
    if (cmd.lookup) begin
      alpha_r <= vrc_pkg::ONE_Q16 - exp_sat;
    end else if (cmd.alpha_last) begin
      alpha_r <= (cur_r.density != 16'd0) ? vrc_pkg::ONE_Q16 : 17'd0;
    end
    if (cmd.wt) begin
      w_r <= w_prod[32:16];
    end
    if (cmd.retire && !cur_r.last_sample) begin
      held_depth_r   <= cur_r.depth;
      held_density_r <= cur_r.density;
      held_red_r     <= cur_r.red_in;
      held_green_r   <= cur_r.green_in;
      held_blue_r    <= cur_r.blue_in;
    end
    if (cmd.emit) begin
      out_data_r.weight    <= w_r[16] ? 16'hFFFF : w_r[15:0];
      out_data_r.red_out   <= cmd.use_cur ? sum_red_r : 16'd0;
      out_data_r.green_out <= cmd.use_cur ? sum_green_r : 16'd0;
      out_data_r.blue_out  <= cmd.use_cur ? sum_blue_r : 16'd0;
      out_data_r.ray_end   <= cmd.use_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holding_r   <= 1'b0;
      trans_r     <= vrc_pkg::ONE_Q16;
      sum_red_r   <= 16'd0;
      sum_green_r <= 16'd0;
      sum_blue_r  <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.retire) begin
        if (cur_r.last_sample) begin
          holding_r   <= 1'b0;
          trans_r     <= vrc_pkg::ONE_Q16;
          sum_red_r   <= 16'd0;
          sum_green_r <= 16'd0;
          sum_blue_r  <= 16'd0;
        end else begin
          holding_r <= 1'b1;
        end
      end else begin
        if (cmd.wt) begin
          trans_r <= t_prod[32:16];
        end
        if (cmd.col) begin
          sum_red_r   <= r_sum[16] ? 16'hFFFF : r_sum[15:0];
          sum_green_r <= g_sum[16] ? 16'hFFFF : g_sum[15:0];
          sum_blue_r  <= b_sum[16] ? 16'hFFFF : b_sum[15:0];
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

@@ src/volume_render_compositor.sv @@
// channel  direction  payload    transfer when
// in_      input      vrc_in_t   in_valid & !in_stall
// out_     output     vrc_out_t  out_valid & !out_stall
//
// A sample with no held predecessor and not last is captured, then retired. A held
// sample is composited when the next one arrives; a last sample then adds steps for
// its own weight. One sample at a time: multiply, table, weight, color.
// Synchronous active-low reset empties the ray: transmittance one, sums zero.
// A stalled output holds its result; the sequencer waits only when it must
// load a new result while the previous one is still stalled.
module volume_render_compositor (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  vrc_pkg::vrc_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output vrc_pkg::vrc_out_t out_data
);

  vrc_pkg::vrc_cmd_t cmd;
  vrc_pkg::vrc_sts_t sts;

  vrc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  vrc_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
